### rtl/flta_pkg.sv
// Shared types and constants of the fault-line terrain accumulator.
package flta_pkg;

  // Width of the divider's dividend (magnitude of (max - min) * k).
  localparam int DVD_W = 28;
  // Width of the divider's divisor (the fault count register).
  localparam int DVS_W = 11;
  // Width of the running cross-product value over the grid.
  localparam int SIDE_W = 20;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_FAULT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EQUAL     = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [1:0] STAT_OUTSIDE   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_COLS  = 3'd0;
  localparam logic [2:0] REG_ROWS  = 3'd1;
  localparam logic [2:0] REG_MIN   = 3'd2;
  localparam logic [2:0] REG_MAX   = 3'd3;
  localparam logic [2:0] REG_COUNT = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SIDE_A,
    S_SIDE_B,
    S_DIV,
    S_SWEEP,
    S_DRAIN,
    S_READ,
    S_RESP
  } seq_state_t;

endpackage

### rtl/flta_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
module flta_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [flta_pkg::DVD_W-1:0] dividend,
  input  logic [flta_pkg::DVS_W-1:0] divisor,
  output logic                       busy,
  output logic [flta_pkg::DVD_W-1:0] quotient
);

  localparam int CW = $clog2(flta_pkg::DVD_W + 1);

  logic                       busy_r;
  logic [CW-1:0]              cnt_r;
  logic [flta_pkg::DVD_W-1:0] quo_r;
  logic [flta_pkg::DVS_W-1:0] rem_r;
  logic [flta_pkg::DVS_W-1:0] dvs_r;
  logic [flta_pkg::DVS_W:0]   rem_sh;
  logic [flta_pkg::DVS_W:0]   rem_diff;
  logic                       fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign rem_sh   = {rem_r, quo_r[flta_pkg::DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign fits     = (rem_sh >= {1'b0, dvs_r});

  // Control: busy from a start until every dividend bit has been shifted through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(flta_pkg::DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: the quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[flta_pkg::DVD_W-2:0], fits};
      rem_r <= fits ? rem_diff[flta_pkg::DVS_W-1:0] : rem_sh[flta_pkg::DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### rtl/fault_line_terrain_accumulate.sv
// Top level of the fault-line terrain accumulator: sequencer, height memory and ports.
//
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tuser kind, tdata endpoints and read cell
// out_     master     out_tvalid/out_tready tdata height, status, faults applied
// cfg_     slave      cfg_valid/cfg_ready   cfg_index register, cfg_data value
//
// A fault runs a multiply, the cross-product value at the grid origin, the divider
// for the step size, then one grid cell per cycle through the memory's read-modify-write.
// A clear writes one memory word per cycle over the whole memory.
// A read passes through S_READ to the response; an error or an unused kind goes straight to it.
// After reset a clearing pass over the whole memory runs before in_tready rises.
// One item is in work at a time; a result waiting on out_tready holds the next item.
module fault_line_terrain_accumulate #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: point_a_col, point_a_row, point_b_col, point_b_row,
  // read_col, read_row (8 bits each).
  input  logic [47:0] in_tdata,
  // Fields from bit 0: kind (2 bits).
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: cell_height (32), status (2), faults_applied (11), zero fill (3).
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = flta_pkg::SIDE_W;

  flta_pkg::seq_state_t state_r, state_nxt;

  // Configuration registers.
  logic [8:0]  cols_r, rows_r;
  logic [15:0] min_r, max_r;
  logic [10:0] count_r;
  logic [8:0]  cols_eff, rows_eff;

  // Item fields.
  logic [1:0] kind;
  logic [7:0] pa_col, pa_row, pb_col, pb_row, rd_col, rd_row;

  // Sequencer and datapath registers.
  logic [10:0]                k_r;
  logic                       clr_reply_r;
  logic [7:0]                 ax_r, ay_r;
  logic signed [8:0]          dx_r, dy_r;
  logic signed [16:0]         diff_r;
  logic signed [28:0]         prod_r;
  logic signed [17:0]         step_r;
  logic signed [SW-1:0]       side_r, row_side_r;
  logic [8:0]                 x_r, y_r;
  logic [AW-1:0]              addr_r, row_base_r, wr_addr_r;
  logic                       wr_pend_r, hit_r;
  logic [31:0]                res_height_r;
  logic [1:0]                 res_status_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [47:0]                out_data_r;

  // Memory and its ports.
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, rd_in_addr;
  logic [31:0]   mem_wdata;

  // Combinational helpers.
  logic                       out_of_grid, pts_equal, exhausted, rd_outside, last_cell;
  logic                       out_load, div_start, div_busy;
  logic [flta_pkg::DVD_W-1:0] div_quot, prod_abs_cut;
  logic [28:0]                prod_abs;
  logic [17:0]                q_mag, q_signed;
  logic signed [17:0]         step_calc;
  logic signed [17:0]         mul_a, mul_b;
  logic signed [SW-1:0]       dx_ext, dy_ext;
  logic [32:0]                sum;
  logic [31:0]                sat_sum;

  // Unpack the input transfer.
  assign kind   = in_tuser;
  assign pa_col = in_tdata[7:0];
  assign pa_row = in_tdata[15:8];
  assign pb_col = in_tdata[23:16];
  assign pb_row = in_tdata[31:24];
  assign rd_col = in_tdata[39:32];
  assign rd_row = in_tdata[47:40];

  // Grid size in use: zero acts as one, values above the maximum clamp to it.
  always_comb begin
    if (cols_r == 9'd0) begin
      cols_eff = 9'd1;
    end else if (32'(cols_r) > MAX_COLS) begin
      cols_eff = 9'(MAX_COLS);
    end else begin
      cols_eff = cols_r;
    end
    if (rows_r == 9'd0) begin
      rows_eff = 9'd1;
    end else if (32'(rows_r) > MAX_ROWS) begin
      rows_eff = 9'(MAX_ROWS);
    end else begin
      rows_eff = rows_r;
    end
  end

  // Checks on an arriving item.
  assign out_of_grid = ({1'b0, pa_col} >= cols_eff) || ({1'b0, pb_col} >= cols_eff) ||
                       ({1'b0, pa_row} >= rows_eff) || ({1'b0, pb_row} >= rows_eff);
  assign pts_equal   = (pa_col == pb_col) && (pa_row == pb_row);
  assign exhausted   = (k_r >= count_r);
  assign rd_outside  = ({1'b0, rd_col} >= cols_eff) || ({1'b0, rd_row} >= rows_eff);
  assign rd_in_addr  = AW'(32'(rd_row) * MAX_COLS + 32'(rd_col));
  assign last_cell   = (x_r == cols_eff - 9'd1) && (y_r == rows_eff - 9'd1);

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 9'd256;
      rows_r  <= 9'd256;
      min_r   <= 16'd0;
      max_r   <= 16'd32;
      count_r <= 11'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        flta_pkg::REG_COLS:  cols_r  <= cfg_data[8:0];
        flta_pkg::REG_ROWS:  rows_r  <= cfg_data[8:0];
        flta_pkg::REG_MIN:   min_r   <= cfg_data;
        flta_pkg::REG_MAX:   max_r   <= cfg_data;
        flta_pkg::REG_COUNT: count_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Divider for the step size.
  assign prod_abs     = prod_r[28] ? (~prod_r + 29'd1) : prod_r;
  assign prod_abs_cut = prod_abs[flta_pkg::DVD_W-1:0];

  flta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs_cut),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Step = max - (max - min) * k / count, truncated toward zero.
  assign q_mag     = div_quot[17:0];
  assign q_signed  = prod_r[28] ? (~q_mag + 18'd1) : q_mag;
  assign step_calc = $signed({{2{max_r[15]}}, max_r} - q_signed);

  // Products for the cross-product value at the grid origin.
  assign mul_a  = $signed({1'b0, ay_r}) * dx_r;
  assign mul_b  = $signed({1'b0, ax_r}) * dy_r;
  assign dx_ext = {{(SW-9){dx_r[8]}}, dx_r};
  assign dy_ext = {{(SW-9){dy_r[8]}}, dy_r};

  // Saturating add of the step to the cell value from the registered read port.
  assign sum = {rd_data_r[31], rd_data_r} + {{15{step_r[17]}}, step_r};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat_sum = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_sum = sum[31:0];
    end
  end

  // Height memory: one write port, one registered read port.
  assign mem_raddr = (state_r == flta_pkg::S_IDLE) ? rd_in_addr : addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flta_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_r;
    mem_wdata = sat_sum;
    case (state_r)
      flta_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = '0;
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_reply_r ? flta_pkg::S_RESP : flta_pkg::S_IDLE;
        end
      end
      flta_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (kind)
            flta_pkg::KIND_CLEAR: state_nxt = flta_pkg::S_CLEAR;
            flta_pkg::KIND_FAULT: begin
              if (out_of_grid || pts_equal || exhausted) begin
                state_nxt = flta_pkg::S_RESP;
              end else begin
                state_nxt = flta_pkg::S_MUL;
              end
            end
            flta_pkg::KIND_READ: begin
              state_nxt = rd_outside ? flta_pkg::S_RESP : flta_pkg::S_READ;
            end
            default: state_nxt = flta_pkg::S_RESP;
          endcase
        end
      end
      flta_pkg::S_MUL: state_nxt = flta_pkg::S_SIDE_A;
      flta_pkg::S_SIDE_A: begin
        div_start = 1'b1;
        state_nxt = flta_pkg::S_SIDE_B;
      end
      flta_pkg::S_SIDE_B: state_nxt = flta_pkg::S_DIV;
      flta_pkg::S_DIV: begin
        if (!div_busy) begin
          state_nxt = flta_pkg::S_SWEEP;
        end
      end
      flta_pkg::S_SWEEP: begin
        mem_we = wr_pend_r && hit_r;
        if (last_cell) begin
          state_nxt = flta_pkg::S_DRAIN;
        end
      end
      flta_pkg::S_DRAIN: begin
        mem_we    = wr_pend_r && hit_r;
        state_nxt = flta_pkg::S_RESP;
      end
      flta_pkg::S_READ: state_nxt = flta_pkg::S_RESP;
      flta_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = flta_pkg::S_IDLE;
        end
      end
      default: state_nxt = flta_pkg::S_IDLE;
    endcase
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      k_r         <= '0;
      clr_reply_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      wr_pend_r <= (state_r == flta_pkg::S_SWEEP);
      case (state_r)
        flta_pkg::S_CLEAR: begin
          addr_r <= (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + 1'b1;
        end
        flta_pkg::S_IDLE: begin
          if (in_tvalid) begin
            addr_r      <= '0;
            clr_reply_r <= (kind == flta_pkg::KIND_CLEAR);
            if (kind == flta_pkg::KIND_CLEAR) begin
              k_r <= '0;
            end
          end
        end
        flta_pkg::S_SWEEP: begin
          if (x_r == cols_eff - 9'd1) begin
            addr_r <= row_base_r + AW'(MAX_COLS);
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        flta_pkg::S_DRAIN: k_r <= k_r + 11'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      flta_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_height_r <= '0;
          res_status_r <= flta_pkg::STAT_OK;
          x_r          <= '0;
          y_r          <= '0;
          row_base_r   <= '0;
          ax_r         <= pa_col;
          ay_r         <= pa_row;
          dx_r         <= $signed({1'b0, pb_col} - {1'b0, pa_col});
          dy_r         <= $signed({1'b0, pb_row} - {1'b0, pa_row});
          diff_r       <= $signed({max_r[15], max_r} - {min_r[15], min_r});
          if (kind == flta_pkg::KIND_FAULT) begin
            if (out_of_grid) begin
              res_status_r <= flta_pkg::STAT_OUTSIDE;
            end else if (pts_equal) begin
              res_status_r <= flta_pkg::STAT_EQUAL;
            end else if (exhausted) begin
              res_status_r <= flta_pkg::STAT_EXHAUSTED;
            end
          end else if (kind == flta_pkg::KIND_READ && rd_outside) begin
            res_status_r <= flta_pkg::STAT_OUTSIDE;
          end
        end
      end
      flta_pkg::S_MUL: prod_r <= diff_r * $signed({1'b0, k_r});
      flta_pkg::S_SIDE_A: side_r <= {{(SW-18){mul_a[17]}}, mul_a};
      flta_pkg::S_SIDE_B: begin
        side_r     <= side_r - {{(SW-18){mul_b[17]}}, mul_b};
        row_side_r <= side_r - {{(SW-18){mul_b[17]}}, mul_b};
      end
      flta_pkg::S_DIV: begin
        if (!div_busy) begin
          step_r <= step_calc;
        end
      end
      flta_pkg::S_SWEEP: begin
        hit_r     <= (side_r > 0);
        wr_addr_r <= addr_r;
        if (x_r == cols_eff - 9'd1) begin
          x_r        <= '0;
          y_r        <= y_r + 9'd1;
          row_base_r <= row_base_r + AW'(MAX_COLS);
          row_side_r <= row_side_r - dx_ext;
          side_r     <= row_side_r - dx_ext;
        end else begin
          x_r    <= x_r + 9'd1;
          side_r <= side_r + dy_ext;
        end
      end
      flta_pkg::S_READ: res_height_r <= rd_data_r;
      default: ;
    endcase
  end

  // Output register: loaded from the result, cleared by a transfer.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'b000, k_r, res_status_r, res_height_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The cell sweep stays inside the grid in use.
  a_sweep_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flta_pkg::S_SWEEP) |-> (x_r < cols_eff && y_r < rows_eff))
    else $error("sweep position outside the grid");

  // Every memory write lands inside the memory.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < DEPTH))
    else $error("memory write address out of range");

  // A fault is only applied while faults remain.
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flta_pkg::S_DRAIN) |-> (k_r < count_r))
    else $error("fault applied past the fault count");

  // The step size is settled before the sweep uses it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flta_pkg::S_SWEEP) |-> !div_busy)
    else $error("divider still busy during sweep");

  // No item is taken during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flta_pkg::S_CLEAR) |-> !in_tready)
    else $error("input taken during clearing pass");

endmodule

### tb/tb_fault_line_terrain_accumulate.sv
// Self-checking testbench for the fault-line terrain accumulator with a scoreboard class.
module tb_fault_line_terrain_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  // Kind code that the block answers with a plain OK result and no other effect.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles to let pass after the last result before touching the registers or ending.
  localparam int DRAIN_CYCLES = 8;
  // Long receiver hold-off, so that a result waits and the input stalls behind it.
  // It outlasts two of the slowest small-grid faults back to back.
  localparam int HOLD_CYCLES = 2000;
  // The slowest correct run is made up of the clearing pass after reset, three clears
  // and one full-grid fault, which each cover the whole grid, and about 80 small-grid items with
  // receiver stalls. The limit takes that about four times over.
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  // One expected result.
  typedef struct {
    logic signed [31:0] height;
    logic [1:0]         status;
    logic [10:0]        applied;
  } terrain_result_t;

  // Height grid predictor and the results it waits for.
  class terrain_scoreboard;
    int              heights[MAX_ROWS * MAX_COLS];
    logic [10:0]     faults_done;
    logic [8:0]      cols_reg;
    logic [8:0]      rows_reg;
    logic [15:0]     min_reg;
    logic [15:0]     max_reg;
    logic [10:0]     count_reg;
    terrain_result_t awaited_results[$];
    int              mismatches;
    int              checked;
    int              items_seen;
    int              faults_ok;
    int              reads_seen;
    int              clears_seen;
    int              rejected[4];

    function new();
      foreach (heights[i]) heights[i] = 0;
      faults_done = '0;
      cols_reg = 9'd256;
      rows_reg = 9'd256;
      min_reg = 16'd0;
      max_reg = 16'd32;
      count_reg = 11'd64;
      mismatches = 0;
      checked = 0;
      items_seen = 0;
      faults_ok = 0;
      reads_seen = 0;
      clears_seen = 0;
      foreach (rejected[i]) rejected[i] = 0;
    endfunction

    // Zero means one; anything past the grid limit means the limit.
    function longint eff_size(logic [8:0] v, longint limit);
      if (v == 9'd0) return 1;
      return (longint'(v) > limit) ? limit : longint'(v);
    endfunction

    function longint eff_cols();
      return eff_size(cols_reg, MAX_COLS);
    endfunction

    function longint eff_rows();
      return eff_size(rows_reg, MAX_ROWS);
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] val);
      case (idx)
        flta_pkg::REG_COLS:  cols_reg = val[8:0];
        flta_pkg::REG_ROWS:  rows_reg = val[8:0];
        flta_pkg::REG_MIN:   min_reg = val;
        flta_pkg::REG_MAX:   max_reg = val;
        flta_pkg::REG_COUNT: count_reg = val[10:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted input transfer to the grid and queue its result.
    function void note_accepted_item(logic [1:0] kind, logic [47:0] word);
      terrain_result_t want;
      longint ax, ay, bx, by, rc, rr, ncols, nrows;
      longint hi, lo, step, side, total;
      int idx;
      want.height = '0;
      want.status = flta_pkg::STAT_OK;
      ncols = eff_cols();
      nrows = eff_rows();
      ax = word[7:0];
      ay = word[15:8];
      bx = word[23:16];
      by = word[31:24];
      rc = word[39:32];
      rr = word[47:40];
      items_seen++;
      case (kind)
        flta_pkg::KIND_CLEAR: begin
          foreach (heights[i]) heights[i] = 0;
          faults_done = '0;
          clears_seen++;
        end
        flta_pkg::KIND_FAULT: begin
          // Outside the grid wins over equal endpoints, which win over an exhausted count.
          if (ax >= ncols || bx >= ncols || ay >= nrows || by >= nrows) begin
            want.status = flta_pkg::STAT_OUTSIDE;
          end else if (ax == bx && ay == by) begin
            want.status = flta_pkg::STAT_EQUAL;
          end else if (faults_done >= count_reg) begin
            want.status = flta_pkg::STAT_EXHAUSTED;
          end else begin
            hi = longint'($signed(max_reg));
            lo = longint'($signed(min_reg));
            step = hi - ((hi - lo) * longint'(faults_done)) / longint'(count_reg);
            for (longint y = 0; y < nrows; y++) begin
              for (longint x = 0; x < ncols; x++) begin
                side = (x - ax) * (by - ay) - (y - ay) * (bx - ax);
                if (side > 0) begin
                  idx = int'(y * MAX_COLS + x);
                  total = longint'(heights[idx]) + step;
                  if (total > 64'sd2147483647) total = 64'sd2147483647;
                  if (total < -64'sd2147483648) total = -64'sd2147483648;
                  heights[idx] = int'(total);
                end
              end
            end
            faults_done = faults_done + 11'd1;
            faults_ok++;
          end
          if (want.status != flta_pkg::STAT_OK) rejected[want.status]++;
        end
        flta_pkg::KIND_READ: begin
          reads_seen++;
          if (rc >= ncols || rr >= nrows) want.status = flta_pkg::STAT_OUTSIDE;
          else want.height = heights[int'(rr * MAX_COLS + rc)];
        end
        default: ;
      endcase
      want.applied = faults_done;
      awaited_results.push_back(want);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s at result %0d: got %0d, expected %0d", what, checked, got, want);
      mismatches++;
    endtask

    // Compare one result transfer against the oldest expectation.
    task check_result(logic [47:0] word);
      terrain_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing expected", longint'(word), 0);
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (word[31:0] !== want.height)
        report_mismatch("cell_height", longint'($signed(word[31:0])), longint'(want.height));
      if (word[33:32] !== want.status)
        report_mismatch("status", longint'(word[33:32]), longint'(want.status));
      if (word[44:34] !== want.applied)
        report_mismatch("faults_applied", longint'(word[44:34]), longint'(want.applied));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  terrain_scoreboard sb;
  int unsigned sender_idle_pct = 13;
  int unsigned receiver_idle_pct = 87;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int clears_left = 2;

  fault_line_terrain_accumulate #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: check every transfer, stall at random or for a requested long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Offer one item and wait for its transfer; valid stays high for a following item.
  task automatic send_item(logic [1:0] kind, logic [47:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_accepted_item(kind, word);
  endtask

  task automatic send_fault(logic [7:0] ac, logic [7:0] ar, logic [7:0] bc, logic [7:0] br);
    logic [31:0] noise;
    noise = $urandom;
    send_item(flta_pkg::KIND_FAULT, {noise[15:0], br, bc, ar, ac});
  endtask

  task automatic send_read(logic [7:0] rc, logic [7:0] rr);
    send_item(flta_pkg::KIND_READ, {rr, rc, 32'($urandom)});
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
  endtask

  task automatic write_config(logic [8:0] c, logic [8:0] r, logic [15:0] lo, logic [15:0] hi,
                              logic [10:0] cnt);
    write_reg(flta_pkg::REG_COLS, 16'(c));
    write_reg(flta_pkg::REG_ROWS, 16'(r));
    write_reg(flta_pkg::REG_MIN, lo);
    write_reg(flta_pkg::REG_MAX, hi);
    write_reg(flta_pkg::REG_COUNT, 16'(cnt));
    cfg_valid <= 1'b0;
  endtask

  // Small grids mostly, with an occasional zero or oversized dimension against a tiny other one.
  task automatic random_config();
    logic [8:0]  c, r;
    logic [10:0] cnt;
    case ($urandom_range(9))
      0: c = 9'd0;
      1: c = 9'($urandom_range(257, 511));
      default: c = 9'($urandom_range(2, 16));
    endcase
    if (c > 9'd16) r = 9'($urandom_range(1, 2));
    else if ($urandom_range(9) == 0) r = 9'd0;
    else r = 9'($urandom_range(1, 16));
    case ($urandom_range(7))
      0: cnt = 11'd0;
      1: cnt = 11'h7FF;
      default: cnt = 11'($urandom_range(1, 40));
    endcase
    write_config(c, r, 16'($urandom), 16'($urandom), cnt);
  endtask

  // One random item: mostly well-formed faults and in-grid reads, some noise.
  task automatic random_item();
    int unsigned pick, sub;
    longint nc, nr;
    logic [7:0] ac, ar, bc, br;
    logic [47:0] noise;
    pick = $urandom_range(99);
    sub = $urandom_range(9);
    nc = sb.eff_cols();
    nr = sb.eff_rows();
    noise = {16'($urandom), 32'($urandom)};
    if (pick < 3 && clears_left > 0) begin
      clears_left--;
      send_item(flta_pkg::KIND_CLEAR, noise);
    end else if (pick < 52) begin
      ac = 8'($urandom_range(32'(nc - 1)));
      ar = 8'($urandom_range(32'(nr - 1)));
      bc = 8'($urandom_range(32'(nc - 1)));
      br = 8'($urandom_range(32'(nr - 1)));
      if (sub == 0) begin
        {br, bc, ar, ac} = noise[31:0];
      end else if (sub == 1) begin
        bc = ac;
        br = ar;
      end else if (nc * nr > 1) begin
        while (bc == ac && br == ar) begin
          bc = 8'($urandom_range(32'(nc - 1)));
          br = 8'($urandom_range(32'(nr - 1)));
        end
      end
      send_fault(ac, ar, bc, br);
    end else if (pick < 93) begin
      if (sub < 2) send_read(noise[7:0], noise[15:8]);
      else send_read(8'($urandom_range(32'(nc - 1))), 8'($urandom_range(32'(nr - 1))));
    end else begin
      send_item(KIND_UNUSED, noise);
    end
  endtask

  task automatic random_section(int section, int count, int unsigned s_idle,
                                int unsigned r_idle);
    wait_drained();
    sender_idle_pct = s_idle;
    receiver_idle_pct = r_idle;
    random_config();
    for (int i = 0; i < count; i++) begin
      // Sender pause until the block has answered everything.
      if (section == 1 && i == count / 2) wait_drained();
      // Long receiver hold-off while items keep coming.
      if (section == 2 && i == 4) hold_requests <= hold_requests + 1;
      random_item();
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full grid, reads at the corners, unused kind, full diagonal fault, equal endpoints.
    send_read(8'd0, 8'd0);
    send_read(8'd255, 8'd255);
    send_item(KIND_UNUSED, '1);
    send_fault(8'd0, 8'd0, 8'd255, 8'd255);
    send_read(8'd255, 8'd0);
    send_read(8'd0, 8'd255);
    send_fault(8'd7, 8'd7, 8'd7, 8'd7);

    // Two by one grid without a clear, zero fault count: error order and kept cells.
    wait_drained();
    write_config(9'd2, 9'd0, 16'h8000, 16'h7FFF, 11'd0);
    send_fault(8'd0, 8'd0, 8'd1, 8'd0);
    send_fault(8'd0, 8'd0, 8'd0, 8'd0);
    send_fault(8'd2, 8'd0, 8'd0, 8'd0);
    send_fault(8'd5, 8'd0, 8'd5, 8'd0);
    send_read(8'd0, 8'd1);
    send_read(8'd1, 8'd0);

    // Oversized column count, two rows, widest step range and largest fault count.
    wait_drained();
    write_config(9'h1FF, 9'd2, 16'h8000, 16'h7FFF, 11'h7FF);
    send_fault(8'd0, 8'd0, 8'd0, 8'd1);
    send_fault(8'd255, 8'd1, 8'd0, 8'd0);
    send_read(8'd255, 8'd1);
    send_read(8'd0, 8'd1);
    send_read(8'd0, 8'd2);

    // Oversized row count, reversed step range, count of one: exhausted, then clear.
    wait_drained();
    write_config(9'd2, 9'h1FF, 16'h7FFF, 16'h8000, 11'd1);
    send_fault(8'd0, 8'd0, 8'd1, 8'd255);
    send_item(flta_pkg::KIND_CLEAR, {16'($urandom), 32'($urandom)});
    send_fault(8'd1, 8'd0, 8'd0, 8'd255);
    send_read(8'd0, 8'd128);
    send_read(8'd1, 8'd255);

    random_section(0, 26, 13, 87);
    random_section(1, 26, 87, 13);
    random_section(2, 26, 0, 0);
    wait_drained();

    $display("Covered %0d items: %0d faults applied, %0d reads, %0d clears, %0d results checked.",
             sb.items_seen, sb.faults_ok, sb.reads_seen, sb.clears_seen, sb.checked);
    $display("Rejected faults: %0d equal endpoints, %0d exhausted, %0d outside the grid.",
             sb.rejected[flta_pkg::STAT_EQUAL], sb.rejected[flta_pkg::STAT_EXHAUSTED],
             sb.rejected[flta_pkg::STAT_OUTSIDE]);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with results still outstanding");
    $display("== FAIL ==");
    $finish;
  end

endmodule
